>>> rtl/gfai_pkg.sv
// ----------------------------------------------------------------------------
// gfai_pkg: shared types, constants and saturating helpers
// Fixed-point Q24.24 words, item structs and the shared arithmetic unit's command and response.
// ----------------------------------------------------------------------------
package gfai_pkg;

   localparam int W          = 48;
   localparam int F          = 24;
   localparam int MASS_FRAC  = 16;
   localparam int GRAV_FRAC  = 32;
   localparam int DT_FRAC    = 24;
   localparam int CFG_W      = 32;
   localparam int MCAND_W    = 64;
   localparam int NUM_W      = 2 * W;
   localparam int PROD_W     = MCAND_W + W;
   localparam int CNT_W      = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int MUL_STEPS  = W;
   localparam int DIV_STEPS  = NUM_W;
   localparam int SQRT_STEPS = NUM_W / 2;
   localparam int P_SHIFT    = GRAV_FRAC + 2 * MASS_FRAC - F;

   localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_OWN_MASS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRAVITY    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TIME_STEP  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INIT_POS_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INIT_POS_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INIT_VEL_X = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_INIT_VEL_Y = 3'd6;

   typedef enum logic [1:0] {
      OP_MUL,
      OP_DIV,
      OP_SQRT
   } op_type;

   typedef struct packed {
      logic              start;
      op_type            op;
      logic [NUM_W-1:0]  num;
      logic [W-1:0]      den;
   } unit_cmd_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] res;
   } unit_rsp_type;

   typedef struct packed {
      logic         ovf;
      logic [W-1:0] val;
   } sat_type;

   typedef struct packed {
      logic signed [W-1:0] other_pos_x;
      logic signed [W-1:0] other_pos_y;
      logic [CFG_W-1:0]    other_mass;
      logic                restart;
      logic                last_body;
   } req_type;

   typedef struct packed {
      logic signed [W-1:0] new_pos_x;
      logic signed [W-1:0] new_pos_y;
      logic signed [W-1:0] new_vel_x;
      logic signed [W-1:0] new_vel_y;
      logic                saturated;
   } rsp_type;

   function automatic sat_type sat_add(logic [W-1:0] a, logic [W-1:0] b);
      logic [W:0] s;
      sat_type    r;
      s     = {a[W-1], a} + {b[W-1], b};
      r.ovf = s[W] ^ s[W-1];
      r.val = r.ovf ? (s[W] ? MINW : MAXW) : s[W-1:0];
      return r;
   endfunction

   function automatic sat_type sat_sub(logic [W-1:0] a, logic [W-1:0] b);
      logic [W:0] s;
      sat_type    r;
      s     = {a[W-1], a} - {b[W-1], b};
      r.ovf = s[W] ^ s[W-1];
      r.val = r.ovf ? (s[W] ? MINW : MAXW) : s[W-1:0];
      return r;
   endfunction

   function automatic logic [W-1:0] mag(logic [W-1:0] x);
      return x[W-1] ? (~x + 1'b1) : x;
   endfunction

   function automatic logic [W-1:0] with_sign(logic neg, logic [W-1:0] m);
      return neg ? (~m + 1'b1) : m;
   endfunction

   // saturate an unsigned magnitude to the largest positive word
   function automatic sat_type clamp(logic [PROD_W-1:0] x);
      sat_type r;
      r.ovf = |x[PROD_W-1:W-1];
      r.val = r.ovf ? MAXW : {1'b0, x[W-2:0]};
      return r;
   endfunction

endpackage

>>> rtl/gfai_unit.sv
// ----------------------------------------------------------------------------
// gfai_unit: shared iterative arithmetic unit
// Shift-add multiply, restoring divide and digit-by-digit square root, one bit
// (or one root digit) per cycle. Result holds after the done pulse.
// ----------------------------------------------------------------------------
module gfai_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  gfai_pkg::unit_cmd_type cmd,
   output gfai_pkg::unit_rsp_type rsp
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   gfai_pkg::op_type                 op_ff, op_in;
   logic [gfai_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [gfai_pkg::MCAND_W-1:0]     hi_ff, hi_in;
   logic [gfai_pkg::W-1:0]           lo_ff, lo_in;
   logic [gfai_pkg::MCAND_W-1:0]     mcand_ff, mcand_in;
   logic [gfai_pkg::W-1:0]           den_ff, den_in;
   logic [gfai_pkg::NUM_W-1:0]       sh_ff, sh_in;
   logic [gfai_pkg::W+2:0]           rem_ff, rem_in;

   logic [gfai_pkg::MCAND_W:0]       mul_sum;
   logic [gfai_pkg::W:0]             div_sh;
   logic                             div_ge;
   logic [gfai_pkg::W+2:0]           sq_sh;
   logic [gfai_pkg::W+2:0]           sq_trial;
   logic                             sq_ge;

   assign mul_sum  = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);
   assign div_sh   = {rem_ff[gfai_pkg::W-1:0], sh_ff[gfai_pkg::NUM_W-1]};
   assign div_ge   = div_sh >= {1'b0, den_ff};
   assign sq_sh    = {rem_ff[gfai_pkg::W:0], sh_ff[gfai_pkg::NUM_W-1 -: 2]};
   assign sq_trial = {1'b0, lo_ff, 2'b01};
   assign sq_ge    = sq_sh >= sq_trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      mcand_in = mcand_ff;
      den_in   = den_ff;
      sh_in    = sh_ff;
      rem_in   = rem_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         op_in    = cmd.op;
         hi_in    = '0;
         lo_in    = (cmd.op == gfai_pkg::OP_MUL) ? cmd.den : '0;
         mcand_in = cmd.num[gfai_pkg::MCAND_W-1:0];
         den_in   = cmd.den;
         sh_in    = cmd.num;
         rem_in   = '0;
         unique case (cmd.op)
            gfai_pkg::OP_MUL:  cnt_in = gfai_pkg::CNT_W'(gfai_pkg::MUL_STEPS - 1);
            gfai_pkg::OP_DIV:  cnt_in = gfai_pkg::CNT_W'(gfai_pkg::DIV_STEPS - 1);
            default:           cnt_in = gfai_pkg::CNT_W'(gfai_pkg::SQRT_STEPS - 1);
         endcase
      end else if (busy_ff) begin
         unique case (op_ff)
            gfai_pkg::OP_MUL: begin
               hi_in = mul_sum[gfai_pkg::MCAND_W:1];
               lo_in = {mul_sum[0], lo_ff[gfai_pkg::W-1:1]};
            end
            gfai_pkg::OP_DIV: begin
               rem_in = (gfai_pkg::W+3)'(div_ge ? (div_sh - {1'b0, den_ff}) : div_sh);
               sh_in  = {sh_ff[gfai_pkg::NUM_W-2:0], div_ge};
            end
            default: begin
               rem_in = sq_ge ? (sq_sh - sq_trial) : sq_sh;
               lo_in  = {lo_ff[gfai_pkg::W-2:0], sq_ge};
               sh_in  = {sh_ff[gfai_pkg::NUM_W-3:0], 2'b00};
            end
         endcase
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= gfai_pkg::OP_MUL;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      mcand_ff <= mcand_in;
      den_ff   <= den_in;
      sh_ff    <= sh_in;
      rem_ff   <= rem_in;
   end

   always_comb begin
      rsp.done = done_ff;
      unique case (op_ff)
         gfai_pkg::OP_MUL: rsp.res = {hi_ff, lo_ff};
         gfai_pkg::OP_DIV: rsp.res = gfai_pkg::PROD_W'(sh_ff);
         default:          rsp.res = gfai_pkg::PROD_W'(lo_ff);
      endcase
   end

endmodule

>>> rtl/gravity_force_accumulate_integrate.sv
// ----------------------------------------------------------------------------
// gravity_force_accumulate_integrate: one body of a 2-D direct-sum gravity sim
// Accumulates the pull of each other body and runs an Euler step on the item
// flagged last_body. Q24.24 words, saturating arithmetic with a sticky flag.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_type (other body, flags)
//   rsp_      out        rsp_valid/rsp_stall  rsp_type (position, velocity)
//   csr_      in         csr_wen              csr_index, csr_wdata
//
// An interaction runs six multiplies, one square root and four divides on the
// shared unit; the Euler step adds one divide and two multiplies per axis.
// req_stall is low only while the sequencer is idle; a result waiting in the
// output register blocks only the final write of the next result.
// Reset clears position and velocity to zero, the init registers' reset values.
// ----------------------------------------------------------------------------
module gravity_force_accumulate_integrate (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  gfai_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output gfai_pkg::rsp_type               rsp_data,
   input  logic                            csr_wen,
   input  logic [gfai_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gfai_pkg::W-1:0]          csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SQX,
      ST_SQY,
      ST_ROOT,
      ST_GM,
      ST_P,
      ST_T,
      ST_FM,
      ST_FMUL,
      ST_FDIV,
      ST_ACC,
      ST_DV,
      ST_DP,
      ST_OUT
   } state_type;

   // configuration
   logic [gfai_pkg::CFG_W-1:0] mass_ff, gravity_ff, step_ff;
   logic [gfai_pkg::W-1:0]     ipx_ff, ipy_ff, ivx_ff, ivy_ff;

   state_type                     state_ff, state_in;
   logic                          pend_ff, pend_in;
   logic                          axis_ff, axis_in;
   logic                          ovf_ff, ovf_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   gfai_pkg::rsp_type             rsp_ff, rsp_in;
   gfai_pkg::req_type             item_ff, item_in;
   logic [gfai_pkg::W-1:0]        pos_ff[2], pos_in[2];
   logic [gfai_pkg::W-1:0]        vel_ff[2], vel_in[2];
   logic [gfai_pkg::W-1:0]        frc_ff[2], frc_in[2];
   logic [gfai_pkg::W-1:0]        dmag_ff[2], dmag_in[2];
   logic                          dneg_ff[2], dneg_in[2];
   logic [gfai_pkg::NUM_W-1:0]    sx_ff, sx_in;
   logic [gfai_pkg::W-1:0]        r_ff, r_in;
   logic [gfai_pkg::MCAND_W-1:0]  tmp_ff, tmp_in;
   logic [gfai_pkg::W-1:0]        fm_ff, fm_in;
   logic [gfai_pkg::NUM_W-1:0]    prod_ff, prod_in;

   gfai_pkg::unit_cmd_type        cmd;
   gfai_pkg::unit_rsp_type        urs;
   gfai_pkg::sat_type             sa, sb;

   gfai_unit u_unit (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rsp   (urs)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff    <= gfai_pkg::CFG_W'(65536);
         gravity_ff <= gfai_pkg::CFG_W'(1);
         step_ff    <= gfai_pkg::CFG_W'(16777216);
         ipx_ff     <= '0;
         ipy_ff     <= '0;
         ivx_ff     <= '0;
         ivy_ff     <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            gfai_pkg::REG_OWN_MASS:   mass_ff    <= csr_wdata[gfai_pkg::CFG_W-1:0];
            gfai_pkg::REG_GRAVITY:    gravity_ff <= csr_wdata[gfai_pkg::CFG_W-1:0];
            gfai_pkg::REG_TIME_STEP:  step_ff    <= csr_wdata[gfai_pkg::CFG_W-1:0];
            gfai_pkg::REG_INIT_POS_X: ipx_ff     <= csr_wdata;
            gfai_pkg::REG_INIT_POS_Y: ipy_ff     <= csr_wdata;
            gfai_pkg::REG_INIT_VEL_X: ivx_ff     <= csr_wdata;
            gfai_pkg::REG_INIT_VEL_Y: ivy_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      axis_in      = axis_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      item_in      = item_ff;
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      frc_in       = frc_ff;
      dmag_in      = dmag_ff;
      dneg_in      = dneg_ff;
      sx_in        = sx_ff;
      r_in         = r_ff;
      tmp_in       = tmp_ff;
      fm_in        = fm_ff;
      prod_in      = prod_ff;
      sa           = '0;
      sb           = '0;
      cmd          = '0;
      cmd.op       = gfai_pkg::OP_MUL;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               if (req_data.restart) begin
                  pos_in[0] = ipx_ff;
                  pos_in[1] = ipy_ff;
                  vel_in[0] = ivx_ff;
                  vel_in[1] = ivy_ff;
                  frc_in[0] = '0;
                  frc_in[1] = '0;
                  ovf_in    = 1'b0;
               end
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            sa         = gfai_pkg::sat_sub(item_ff.other_pos_x, pos_ff[0]);
            sb         = gfai_pkg::sat_sub(item_ff.other_pos_y, pos_ff[1]);
            dneg_in[0] = sa.val[gfai_pkg::W-1];
            dneg_in[1] = sb.val[gfai_pkg::W-1];
            dmag_in[0] = gfai_pkg::mag(sa.val);
            dmag_in[1] = gfai_pkg::mag(sb.val);
            ovf_in     = ovf_ff | sa.ovf | sb.ovf;
            state_in   = ST_SQX;
         end
         ST_SQX: begin
            cmd.num = gfai_pkg::NUM_W'(dmag_ff[0]);
            cmd.den = dmag_ff[0];
            if (!pend_ff) begin
               cmd.start = 1'b1;
               pend_in   = 1'b1;
            end else if (urs.done) begin
               pend_in  = 1'b0;
               sx_in    = urs.res[gfai_pkg::NUM_W-1:0];
               state_in = ST_SQY;
            end
         end
         ST_SQY: begin
            cmd.num = gfai_pkg::NUM_W'(dmag_ff[1]);
            cmd.den = dmag_ff[1];
            if (!pend_ff) begin
               cmd.start = 1'b1;
               pend_in   = 1'b1;
            end else if (urs.done) begin
               pend_in  = 1'b0;
               sx_in    = sx_ff + urs.res[gfai_pkg::NUM_W-1:0];
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            cmd.op  = gfai_pkg::OP_SQRT;
            cmd.num = sx_ff;
            if (!pend_ff) begin
               cmd.start = 1'b1;
               pend_in   = 1'b1;
            end else if (urs.done) begin
               pend_in = 1'b0;
               r_in    = urs.res[gfai_pkg::W-1:0];
               // coincident bodies: drop the contribution
               if (urs.res[gfai_pkg::W-1:0] == '0) begin
                  axis_in  = 1'b0;
                  state_in = item_ff.last_body ? ST_ACC : ST_IDLE;
               end else begin
                  state_in = ST_GM;
               end
            end
         end
         ST_GM: begin
            cmd.num = gfai_pkg::NUM_W'(gravity_ff);
            cmd.den = gfai_pkg::W'(mass_ff);
            if (!pend_ff) begin
               cmd.start = 1'b1;
               pend_in   = 1'b1;
            end else if (urs.done) begin
               pend_in  = 1'b0;
               tmp_in   = urs.res[gfai_pkg::MCAND_W-1:0];
               state_in = ST_P;
            end
         end
         ST_P: begin
            cmd.num = gfai_pkg::NUM_W'(tmp_ff);
            cmd.den = gfai_pkg::W'(item_ff.other_mass);
            if (!pend_ff) begin
               cmd.start = 1'b1;
               pend_in   = 1'b1;
            end else if (urs.done) begin
               pend_in  = 1'b0;
               sa       = gfai_pkg::clamp(urs.res >> gfai_pkg::P_SHIFT);
               tmp_in   = gfai_pkg::MCAND_W'(sa.val);
               ovf_in   = ovf_ff | sa.ovf;
               state_in = ST_T;
            end
         end
         ST_T, ST_FM: begin
            cmd.op  = gfai_pkg::OP_DIV;
            cmd.num = gfai_pkg::NUM_W'(tmp_ff[gfai_pkg::W-1:0]) << gfai_pkg::F;
            cmd.den = r_ff;
            if (!pend_ff) begin
               cmd.start = 1'b1;
               pend_in   = 1'b1;
            end else if (urs.done) begin
               pend_in = 1'b0;
               sa      = gfai_pkg::clamp(urs.res);
               ovf_in  = ovf_ff | sa.ovf;
               if (state_ff == ST_T) begin
                  tmp_in   = gfai_pkg::MCAND_W'(sa.val);
                  state_in = ST_FM;
               end else begin
                  fm_in    = sa.val;
                  axis_in  = 1'b0;
                  state_in = ST_FMUL;
               end
            end
         end
         ST_FMUL: begin
            cmd.num = gfai_pkg::NUM_W'(fm_ff);
            cmd.den = dmag_ff[axis_ff];
            if (!pend_ff) begin
               cmd.start = 1'b1;
               pend_in   = 1'b1;
            end else if (urs.done) begin
               pend_in  = 1'b0;
               prod_in  = urs.res[gfai_pkg::NUM_W-1:0];
               state_in = ST_FDIV;
            end
         end
         ST_FDIV: begin
            cmd.op  = gfai_pkg::OP_DIV;
            cmd.num = prod_ff;
            cmd.den = r_ff;
            if (!pend_ff) begin
               cmd.start = 1'b1;
               pend_in   = 1'b1;
            end else if (urs.done) begin
               pend_in         = 1'b0;
               sa              = gfai_pkg::clamp(urs.res);
               sb              = gfai_pkg::sat_add(frc_ff[axis_ff],
                                    gfai_pkg::with_sign(dneg_ff[axis_ff], sa.val));
               frc_in[axis_ff] = sb.val;
               ovf_in          = ovf_ff | sa.ovf | sb.ovf;
               if (!axis_ff) begin
                  axis_in  = 1'b1;
                  state_in = ST_FMUL;
               end else begin
                  axis_in  = 1'b0;
                  state_in = item_ff.last_body ? ST_ACC : ST_IDLE;
               end
            end
         end
         ST_ACC: begin
            cmd.op  = gfai_pkg::OP_DIV;
            cmd.num = gfai_pkg::NUM_W'(gfai_pkg::mag(frc_ff[axis_ff])) << gfai_pkg::MASS_FRAC;
            cmd.den = gfai_pkg::W'(mass_ff);
            if (mass_ff == '0) begin
               // massless body: acceleration pins to full scale, or to zero with no force
               tmp_in   = (frc_ff[axis_ff] == '0) ? '0 : gfai_pkg::MCAND_W'(gfai_pkg::MAXW);
               ovf_in   = ovf_ff | (frc_ff[axis_ff] != '0);
               state_in = ST_DV;
            end else if (!pend_ff) begin
               cmd.start = 1'b1;
               pend_in   = 1'b1;
            end else if (urs.done) begin
               pend_in  = 1'b0;
               sa       = gfai_pkg::clamp(urs.res);
               tmp_in   = gfai_pkg::MCAND_W'(sa.val);
               ovf_in   = ovf_ff | sa.ovf;
               state_in = ST_DV;
            end
         end
         ST_DV: begin
            cmd.num = gfai_pkg::NUM_W'(tmp_ff[gfai_pkg::W-1:0]);
            cmd.den = gfai_pkg::W'(step_ff);
            if (!pend_ff) begin
               cmd.start = 1'b1;
               pend_in   = 1'b1;
            end else if (urs.done) begin
               pend_in         = 1'b0;
               sa              = gfai_pkg::clamp(urs.res >> gfai_pkg::DT_FRAC);
               sb              = gfai_pkg::sat_add(vel_ff[axis_ff],
                                    gfai_pkg::with_sign(frc_ff[axis_ff][gfai_pkg::W-1], sa.val));
               vel_in[axis_ff] = sb.val;
               ovf_in          = ovf_ff | sa.ovf | sb.ovf;
               state_in        = ST_DP;
            end
         end
         ST_DP: begin
            cmd.num = gfai_pkg::NUM_W'(gfai_pkg::mag(vel_ff[axis_ff]));
            cmd.den = gfai_pkg::W'(step_ff);
            if (!pend_ff) begin
               cmd.start = 1'b1;
               pend_in   = 1'b1;
            end else if (urs.done) begin
               pend_in         = 1'b0;
               sa              = gfai_pkg::clamp(urs.res >> gfai_pkg::DT_FRAC);
               sb              = gfai_pkg::sat_add(pos_ff[axis_ff],
                                    gfai_pkg::with_sign(vel_ff[axis_ff][gfai_pkg::W-1], sa.val));
               pos_in[axis_ff] = sb.val;
               ovf_in          = ovf_ff | sa.ovf | sb.ovf;
               if (!axis_ff) begin
                  axis_in  = 1'b1;
                  state_in = ST_ACC;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.new_pos_x   = pos_ff[0];
               rsp_in.new_pos_y   = pos_ff[1];
               rsp_in.new_vel_x   = vel_ff[0];
               rsp_in.new_vel_y   = vel_ff[1];
               rsp_in.saturated   = ovf_ff;
               frc_in[0]          = '0;
               frc_in[1]          = '0;
               ovf_in             = 1'b0;
               state_in           = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         axis_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff[0]    <= '0;
         pos_ff[1]    <= '0;
         vel_ff[0]    <= '0;
         vel_ff[1]    <= '0;
         frc_ff[0]    <= '0;
         frc_ff[1]    <= '0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         axis_ff      <= axis_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         frc_ff       <= frc_in;
      end
      rsp_ff  <= rsp_in;
      item_ff <= item_in;
      dmag_ff <= dmag_in;
      dneg_ff <= dneg_in;
      sx_ff   <= sx_in;
      r_ff    <= r_in;
      tmp_ff  <= tmp_in;
      fm_ff   <= fm_in;
      prod_ff <= prod_in;
   end

endmodule
